[rtl/ssc_pkg.sv]
// shared types, constants and commutation table for the six-step commutator
`default_nettype none
package ssc_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int TIME_IN_W = 32;
    localparam int THR_W     = 11;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 2;
    localparam int MODE_W    = 2;
    localparam int STEP_W    = 3;
    localparam int DUTY_W    = 16;
    localparam int PROD_W    = THR_W + DUTY_W;
    localparam int NUM_STEPS = 6;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    // event codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_CROSS    = 2'd1;
    localparam logic [OP_W-1:0] OP_THROTTLE = 2'd2;

    // motor modes
    localparam logic [MODE_W-1:0] MODE_STOPPED     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN_LOOP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSED_LOOP = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DECREMENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLANKING_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY       = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] RST_INITIAL_PERIOD = 16'd4000;
    localparam logic [CFG_W-1:0] RST_FINAL_PERIOD   = 16'd800;
    localparam logic [CFG_W-1:0] RST_RAMP_STEPS     = 16'd200;
    localparam logic [CFG_W-1:0] RST_RAMP_DECREMENT = 16'd16;
    localparam logic [CFG_W-1:0] RST_BLANKING_TICKS = 16'd200;
    localparam logic [THR_W-1:0] RST_THROTTLE_MIN   = 11'd48;
    localparam logic [CFG_W-1:0] RST_MAX_DUTY       = 16'd1000;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [TIME_IN_W-1:0] time_ticks;
        logic [THR_W-1:0]     throttle;
    } in_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] high_phase;
        logic [PHASE_W-1:0] low_phase;
        logic [PHASE_W-1:0] float_phase;
        logic               drive_off;
        logic [DUTY_W-1:0]  duty;
        logic [MODE_W-1:0]  motor_mode;
        logic               commutated;
        logic               detector_reset;
        logic [STEP_W-1:0]  step_index;
    } out_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] hi;
        logic [PHASE_W-1:0] lo;
        logic [PHASE_W-1:0] fl;
    } phase_set_t;

    localparam phase_set_t PHASE_MAP [NUM_STEPS] = '{
        '{hi: 2'd0, lo: 2'd1, fl: 2'd2},
        '{hi: 2'd0, lo: 2'd2, fl: 2'd1},
        '{hi: 2'd1, lo: 2'd2, fl: 2'd0},
        '{hi: 2'd1, lo: 2'd0, fl: 2'd2},
        '{hi: 2'd2, lo: 2'd0, fl: 2'd1},
        '{hi: 2'd2, lo: 2'd1, fl: 2'd0}
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_OL_STEP,
        ST_OL_SCHED,
        ST_CL_STEP,
        ST_XING,
        ST_XSCHED,
        ST_STOP,
        ST_START,
        ST_MAP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic ol_step;
        logic ol_sched;
        logic cl_step;
        logic xing;
        logic xsched;
        logic stop;
        logic start;
        logic map_check;
        logic mul;
        logic div_start;
        logic sat;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] mode;
        logic              due;
        logic              pending;
        logic              blank_ok;
        logic              cross_none;
        logic              thr_zero;
        logic              thr_below_min;
        logic              full_le_min;
        logic              div_busy;
        logic              out_free;
    } stat_t;

endpackage
`default_nettype wire

[rtl/ssc_div.sv]
// restoring radix-2 divider for the throttle-to-duty mapping
`default_nettype none
module ssc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ssc_pkg::PROD_W-1:0] dividend,
    input  wire logic [ssc_pkg::DUTY_W-1:0] divisor,
    output logic                           busy,
    output logic [ssc_pkg::PROD_W-1:0]     quotient
);
    import ssc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [DUTY_W-1:0] rem_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DUTY_W:0]   partial;
    logic              fits;
    logic [DUTY_W:0]   diff;

    assign partial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits    = partial >= {1'b0, divisor};
    assign diff    = partial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(PROD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            rem_reg <= fits ? diff[DUTY_W-1:0] : partial[DUTY_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/ssc_ctrl.sv]
// sequencing state machine for the six-step commutator
`default_nettype none
module ssc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire ssc_pkg::stat_t stat,
    output ssc_pkg::cmd_t       cmd
);
    import ssc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                case (stat.op)
                    OP_TICK:
                    begin
                        if (stat.mode == MODE_OPEN_LOOP && stat.due)
                        begin
                            state_next = ST_OL_STEP;
                        end
                        else if (stat.mode == MODE_CLOSED_LOOP && stat.pending && stat.due)
                        begin
                            state_next = ST_CL_STEP;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_CROSS:
                    begin
                        if (stat.mode == MODE_CLOSED_LOOP && stat.blank_ok)
                        begin
                            state_next = ST_XING;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_THROTTLE:
                    begin
                        if (stat.thr_zero)
                        begin
                            state_next = ST_STOP;
                        end
                        else if (stat.mode == MODE_STOPPED)
                        begin
                            state_next = ST_START;
                        end
                        else
                        begin
                            state_next = ST_MAP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_OL_STEP:  state_next = ST_OL_SCHED;
            ST_OL_SCHED: state_next = ST_DONE;
            ST_CL_STEP:  state_next = ST_DONE;
            ST_XING:     state_next = stat.cross_none ? ST_DONE : ST_XSCHED;
            ST_XSCHED:   state_next = ST_DONE;
            ST_STOP:     state_next = ST_DONE;
            ST_START:    state_next = ST_MAP;
            ST_MAP:
            begin
                if (stat.thr_below_min || stat.full_le_min)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:      state_next = ST_DONE;
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_OL_STEP:  cmd.ol_step   = 1'b1;
            ST_OL_SCHED: cmd.ol_sched  = 1'b1;
            ST_CL_STEP:  cmd.cl_step   = 1'b1;
            ST_XING:     cmd.xing      = 1'b1;
            ST_XSCHED:   cmd.xsched    = 1'b1;
            ST_STOP:     cmd.stop      = 1'b1;
            ST_START:    cmd.start     = 1'b1;
            ST_MAP:      cmd.map_check = 1'b1;
            ST_MUL:      cmd.mul       = 1'b1;
            ST_DIV_GO:   cmd.div_start = 1'b1;
            ST_SAT:      cmd.sat       = 1'b1;
            ST_DONE:     cmd.load_out  = stat.out_free;
            default:     cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/ssc_datapath.sv]
// registers, time arithmetic, duty mapping and output register of the commutator
`default_nettype none
module ssc_datapath #(
    parameter int TIME_WIDTH    = 32,
    parameter int THROTTLE_FULL = 2047
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ssc_pkg::cmd_t                cmd,
    output ssc_pkg::stat_t                    stat,
    input  wire ssc_pkg::in_item_t            item,
    input  wire logic                         cfg_write,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ssc_pkg::CFG_W-1:0]     cfg_data,
    output ssc_pkg::out_item_t                result,
    output logic                              result_valid,
    input  wire logic                         result_ready
);
    import ssc_pkg::*;

    // configuration
    logic [CFG_W-1:0] initial_period_reg;
    logic [CFG_W-1:0] final_period_reg;
    logic [CFG_W-1:0] ramp_steps_reg;
    logic [CFG_W-1:0] ramp_decrement_reg;
    logic [CFG_W-1:0] blanking_ticks_reg;
    logic [THR_W-1:0] throttle_min_reg;
    logic [CFG_W-1:0] max_duty_reg;

    // captured transaction
    logic [OP_W-1:0]       op_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [THR_W-1:0]      thr_reg;

    // motor state
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [TIME_WIDTH-1:0] next_comm_reg, next_comm_next;
    logic [TIME_WIDTH-1:0] last_comm_reg, last_comm_next;
    logic [TIME_WIDTH-1:0] last_cross_reg, last_cross_next;
    logic [CFG_W-1:0]      ramp_period_reg, ramp_period_next;
    logic [CFG_W-1:0]      ramp_count_reg, ramp_count_next;
    logic [DUTY_W-1:0]     duty_reg, duty_next;
    logic                  pending_reg, pending_next;
    logic                  comm_reg, comm_next;
    logic                  dres_reg, dres_next;

    // scratch
    logic [TIME_WIDTH-1:0] half_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DUTY_W-1:0]     span_reg;

    logic [TIME_WIDTH-1:0] due_diff;
    logic [TIME_WIDTH-1:0] since_comm;
    logic [TIME_WIDTH-1:0] cross_diff;
    logic [STEP_W-1:0]     step_adv;
    logic [CFG_W:0]        period_diff;
    logic [CFG_W-1:0]      period_new;
    logic [CFG_W-1:0]      count_inc;
    logic [THR_W-1:0]      thr_off;
    logic                  div_busy;
    logic [PROD_W-1:0]     quotient;

    out_item_t  result_reg;
    logic       result_valid_reg;
    phase_set_t phases;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_period_reg <= RST_INITIAL_PERIOD;
            final_period_reg   <= RST_FINAL_PERIOD;
            ramp_steps_reg     <= RST_RAMP_STEPS;
            ramp_decrement_reg <= RST_RAMP_DECREMENT;
            blanking_ticks_reg <= RST_BLANKING_TICKS;
            throttle_min_reg   <= RST_THROTTLE_MIN;
            max_duty_reg       <= RST_MAX_DUTY;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INITIAL_PERIOD: initial_period_reg <= cfg_data;
                REG_FINAL_PERIOD:   final_period_reg   <= cfg_data;
                REG_RAMP_STEPS:     ramp_steps_reg     <= cfg_data;
                REG_RAMP_DECREMENT: ramp_decrement_reg <= cfg_data;
                REG_BLANKING_TICKS: blanking_ticks_reg <= cfg_data;
                REG_THROTTLE_MIN:   throttle_min_reg   <= cfg_data[THR_W-1:0];
                REG_MAX_DUTY:       max_duty_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= item.op;
            now_reg <= TIME_WIDTH'(item.time_ticks);
            thr_reg <= item.throttle;
        end
        if (cmd.xing)
        begin
            half_reg <= cross_diff >> 1;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(thr_off) * PROD_W'(max_duty_reg);
            span_reg <= DUTY_W'(THROTTLE_FULL) - DUTY_W'(throttle_min_reg);
        end
    end

    assign due_diff    = now_reg - next_comm_reg;
    assign since_comm  = now_reg - last_comm_reg;
    assign cross_diff  = now_reg - last_cross_reg;
    assign step_adv    = (step_reg == LAST_STEP) ? '0 : step_reg + STEP_W'(1);
    assign period_diff = {1'b0, ramp_period_reg} - {1'b0, ramp_decrement_reg};
    // floor at final_period, also when the decrement would wrap
    assign period_new  = (period_diff[CFG_W] || period_diff[CFG_W-1:0] < final_period_reg)
                         ? final_period_reg : period_diff[CFG_W-1:0];
    assign count_inc   = (ramp_count_reg == '1) ? ramp_count_reg
                                                : ramp_count_reg + CFG_W'(1);
    assign thr_off     = thr_reg - throttle_min_reg;

    always_comb
    begin
        step_next        = step_reg;
        mode_next        = mode_reg;
        next_comm_next   = next_comm_reg;
        last_comm_next   = last_comm_reg;
        last_cross_next  = last_cross_reg;
        ramp_period_next = ramp_period_reg;
        ramp_count_next  = ramp_count_reg;
        duty_next        = duty_reg;
        pending_next     = pending_reg;
        comm_next        = comm_reg;
        dres_next        = dres_reg;

        if (cmd.capture)
        begin
            comm_next = 1'b0;
            dres_next = 1'b0;
        end
        if (cmd.ol_step)
        begin
            step_next        = step_adv;
            last_comm_next   = next_comm_reg;
            ramp_period_next = period_new;
            ramp_count_next  = count_inc;
            comm_next        = 1'b1;
        end
        if (cmd.ol_sched)
        begin
            next_comm_next = now_reg + TIME_WIDTH'(ramp_period_reg);
            if (ramp_count_reg >= ramp_steps_reg)
            begin
                // last open-loop schedule stays pending into closed loop
                mode_next    = MODE_CLOSED_LOOP;
                dres_next    = 1'b1;
                pending_next = 1'b1;
            end
        end
        if (cmd.cl_step)
        begin
            step_next      = step_adv;
            last_comm_next = next_comm_reg;
            pending_next   = 1'b0;
            comm_next      = 1'b1;
        end
        if (cmd.xing)
        begin
            last_cross_next = now_reg;
        end
        if (cmd.xsched)
        begin
            next_comm_next = now_reg + half_reg;
            pending_next   = 1'b1;
        end
        if (cmd.stop)
        begin
            mode_next = MODE_STOPPED;
        end
        if (cmd.start)
        begin
            mode_next        = MODE_OPEN_LOOP;
            ramp_period_next = initial_period_reg;
            ramp_count_next  = '0;
            next_comm_next   = '0;
            last_comm_next   = '0;
            last_cross_next  = '0;
            pending_next     = 1'b0;
            step_next        = '0;
            comm_next        = 1'b1;
        end
        if (cmd.map_check)
        begin
            if (stat.thr_below_min)
            begin
                duty_next = '0;
            end
            else if (stat.full_le_min)
            begin
                duty_next = max_duty_reg;
            end
        end
        if (cmd.sat)
        begin
            duty_next = (quotient > PROD_W'(max_duty_reg)) ? max_duty_reg
                                                           : quotient[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= '0;
            mode_reg        <= MODE_STOPPED;
            next_comm_reg   <= '0;
            last_comm_reg   <= '0;
            last_cross_reg  <= '0;
            ramp_period_reg <= RST_INITIAL_PERIOD;
            ramp_count_reg  <= '0;
            duty_reg        <= '0;
            pending_reg     <= 1'b0;
            comm_reg        <= 1'b0;
            dres_reg        <= 1'b0;
        end
        else
        begin
            step_reg        <= step_next;
            mode_reg        <= mode_next;
            next_comm_reg   <= next_comm_next;
            last_comm_reg   <= last_comm_next;
            last_cross_reg  <= last_cross_next;
            ramp_period_reg <= ramp_period_next;
            ramp_count_reg  <= ramp_count_next;
            duty_reg        <= duty_next;
            pending_reg     <= pending_next;
            comm_reg        <= comm_next;
            dres_reg        <= dres_next;
        end
    end

    ssc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign phases = PHASE_MAP[step_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.high_phase     <= phases.hi;
            result_reg.low_phase      <= phases.lo;
            result_reg.float_phase    <= phases.fl;
            result_reg.drive_off      <= (mode_reg == MODE_STOPPED);
            result_reg.duty           <= duty_reg;
            result_reg.motor_mode     <= mode_reg;
            result_reg.commutated     <= comm_reg;
            result_reg.detector_reset <= dres_reg;
            result_reg.step_index     <= step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        stat.op            = op_reg;
        stat.mode          = mode_reg;
        stat.due           = ~due_diff[TIME_WIDTH-1];
        stat.pending       = pending_reg;
        stat.blank_ok      = since_comm >= TIME_WIDTH'(blanking_ticks_reg);
        stat.cross_none    = (last_cross_reg == '0);
        stat.thr_zero      = (thr_reg == '0);
        stat.thr_below_min = thr_reg < throttle_min_reg;
        stat.full_le_min   = DUTY_W'(THROTTLE_FULL) <= DUTY_W'(throttle_min_reg);
        stat.div_busy      = div_busy;
        stat.out_free      = !result_valid_reg || result_ready;
    end

endmodule
`default_nettype wire

[rtl/sensorless_six_step_commutator_unit.sv]
// top level of the sensorless six-step commutator
// sequence: each transaction is decoded and runs its command states, then a done state
//   registers the result; done waits while the output is stalled, and throttle
//   transactions also wait for the 27-step divider
// flow: one transaction at a time; the next is taken the cycle after the result is registered
// reset: asynchronous active low; registers take defaults, motor stopped at step 0
`default_nettype none
module sensorless_six_step_commutator_unit #(
    parameter int TIME_WIDTH    = 32,
    parameter int THROTTLE_FULL = 2047
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // event channel
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire ssc_pkg::in_item_t            item,
    // result channel
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output ssc_pkg::out_item_t                result,
    // configuration write channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ssc_pkg::CFG_W-1:0]     cfg_data
);
    import ssc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // the user must let registers change only while idle; the block does not enforce it and always takes writes
    assign cfg_ready = 1'b1;

    // controller: one transaction in flight, decode then a short command sequence
    ssc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: motor state, time compares, duty mapping, output register
    ssc_datapath #(
        .TIME_WIDTH    (TIME_WIDTH),
        .THROTTLE_FULL (THROTTLE_FULL)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
`default_nettype wire

[rtl/ssc_checker.sv]
// port-level checks for the commutator and their binding to the top level
`default_nettype none
module ssc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         item_valid,
    input wire logic                         item_ready,
    input wire ssc_pkg::in_item_t            item,
    input wire logic                         result_valid,
    input wire logic                         result_ready,
    input wire ssc_pkg::out_item_t           result
);
    import ssc_pkg::*;

    // stalled event holds
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("event changed while stalled");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // one transaction in flight
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("second transaction taken while busy");

    // a new result only comes out of a transaction in progress
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared with no transaction in progress");

    // detector reset only on the commutation that enters closed loop
    a_detector_reset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.detector_reset |->
            result.commutated && result.motor_mode == MODE_CLOSED_LOOP)
    else $error("detector reset outside closed-loop entry");

endmodule

bind sensorless_six_step_commutator_unit ssc_checker u_ssc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
`default_nettype wire

[test/tb_sensorless_six_step_commutator_unit.sv]
// self-checking testbench for the sensorless six-step commutator top level
`timescale 1ns / 100ps

module tb_sensorless_six_step_commutator_unit;

    import ssc_pkg::*;

    // no-event code, not part of the block's own code list
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // bridge phases
    localparam logic [PHASE_W-1:0] PH_A = 2'd0;
    localparam logic [PHASE_W-1:0] PH_B = 2'd1;
    localparam logic [PHASE_W-1:0] PH_C = 2'd2;

    // throttle full scale, same as the block's default parameter
    localparam logic [31:0] FULL_SCALE = 32'd2047;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_EVENTS = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    in_item_t             item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    out_item_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    sensorless_six_step_commutator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // commutator shadow: register copies, reset values as after rst_n
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  cfg_init_period  = RST_INITIAL_PERIOD;
    logic [CFG_W-1:0]  cfg_final_period = RST_FINAL_PERIOD;
    logic [CFG_W-1:0]  cfg_ramp_steps   = RST_RAMP_STEPS;
    logic [CFG_W-1:0]  cfg_ramp_dec     = RST_RAMP_DECREMENT;
    logic [CFG_W-1:0]  cfg_blanking     = RST_BLANKING_TICKS;
    logic [THR_W-1:0]  cfg_thr_min      = RST_THROTTLE_MIN;
    logic [CFG_W-1:0]  cfg_max_duty     = RST_MAX_DUTY;

    // motor state shadow
    logic [STEP_W-1:0] step_q      = '0;
    logic [MODE_W-1:0] mode_q      = MODE_STOPPED;
    logic [31:0]       next_comm   = '0;
    logic [31:0]       last_comm   = '0;
    logic [31:0]       last_cross  = '0;
    logic [15:0]       period_q    = RST_INITIAL_PERIOD;
    logic [15:0]       ramp_cnt    = '0;
    logic [DUTY_W-1:0] duty_q      = '0;
    logic              sched_armed = 1'b0;

    // events waiting for the driver, outputs waiting for the monitor
    in_item_t  event_queue [$];
    out_item_t expected_outputs [$];

    int unsigned events_queued  = 0;
    int unsigned events_taken   = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_cnt   = 0;
    int unsigned reg_writes     = 0;
    int unsigned settings_used  = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned send_idle_pct  = 9;
    int unsigned recv_idle_pct  = 86;
    int unsigned hold_left      = 0;
    logic        hold_armed     = 1'b0;
    logic        hold_done      = 1'b0;

    // advance the shadow by one event and return the outputs it should produce
    function automatic out_item_t apply_event(in_item_t ev);
        out_item_t         r;
        logic [31:0]       now;
        logic [31:0]       lag;
        logic [31:0]       half;
        logic [31:0]       num;
        logic [31:0]       span;
        logic [31:0]       scaled;
        logic [STEP_W-1:0] nxt;
        logic              fired;
        logic              cl_entry;
        now      = ev.time_ticks;
        lag      = now - next_comm;
        nxt      = (step_q == LAST_STEP) ? '0 : step_q + STEP_W'(1);
        fired    = 1'b0;
        cl_entry = 1'b0;
        r        = '0;
        case (ev.op)
            OP_TICK:
            begin
                // open loop: every due tick steps and shortens the period
                if (mode_q == MODE_OPEN_LOOP)
                begin
                    if (!lag[31])
                    begin
                        step_q    = nxt;
                        last_comm = next_comm;
                        fired     = 1'b1;
                        if (cfg_ramp_dec > period_q || period_q - cfg_ramp_dec < cfg_final_period)
                            period_q = cfg_final_period;
                        else
                            period_q = period_q - cfg_ramp_dec;
                        next_comm = now + {16'd0, period_q};
                        if (ramp_cnt != 16'hFFFF)
                            ramp_cnt = ramp_cnt + 16'd1;
                        // ramp done: last open-loop schedule stays armed
                        if (ramp_cnt >= cfg_ramp_steps)
                        begin
                            mode_q      = MODE_CLOSED_LOOP;
                            cl_entry    = 1'b1;
                            sched_armed = 1'b1;
                        end
                    end
                end
                else if (mode_q == MODE_CLOSED_LOOP && sched_armed && !lag[31])
                begin
                    // each schedule fires once
                    step_q      = nxt;
                    last_comm   = next_comm;
                    fired       = 1'b1;
                    sched_armed = 1'b0;
                end
            end
            OP_CROSS:
            begin
                if (mode_q == MODE_CLOSED_LOOP && (now - last_comm) >= {16'd0, cfg_blanking})
                begin
                    // a stored zero means no crossing seen yet
                    if (last_cross == '0)
                        last_cross = now;
                    else
                    begin
                        half        = (now - last_cross) >> 1;
                        last_cross  = now;
                        next_comm   = now + half;
                        sched_armed = 1'b1;
                    end
                end
            end
            OP_THROTTLE:
            begin
                if (ev.throttle == '0)
                    mode_q = MODE_STOPPED;
                else
                begin
                    if (mode_q == MODE_STOPPED)
                    begin
                        mode_q      = MODE_OPEN_LOOP;
                        period_q    = cfg_init_period;
                        ramp_cnt    = '0;
                        next_comm   = '0;
                        last_comm   = '0;
                        last_cross  = '0;
                        sched_armed = 1'b0;
                        step_q      = '0;
                        fired       = 1'b1;
                    end
                    if (ev.throttle < cfg_thr_min)
                        duty_q = '0;
                    else if (FULL_SCALE <= {21'd0, cfg_thr_min})
                        duty_q = cfg_max_duty;
                    else
                    begin
                        num    = {21'd0, ev.throttle} - {21'd0, cfg_thr_min};
                        span   = FULL_SCALE - {21'd0, cfg_thr_min};
                        scaled = (num * {16'd0, cfg_max_duty}) / span;
                        duty_q = (scaled > {16'd0, cfg_max_duty}) ? cfg_max_duty : scaled[15:0];
                    end
                end
            end
            default:
            begin
                // no event: outputs only
            end
        endcase
        case (step_q)
            3'd0:    {r.high_phase, r.low_phase, r.float_phase} = {PH_A, PH_B, PH_C};
            3'd1:    {r.high_phase, r.low_phase, r.float_phase} = {PH_A, PH_C, PH_B};
            3'd2:    {r.high_phase, r.low_phase, r.float_phase} = {PH_B, PH_C, PH_A};
            3'd3:    {r.high_phase, r.low_phase, r.float_phase} = {PH_B, PH_A, PH_C};
            3'd4:    {r.high_phase, r.low_phase, r.float_phase} = {PH_C, PH_A, PH_B};
            default: {r.high_phase, r.low_phase, r.float_phase} = {PH_C, PH_B, PH_A};
        endcase
        r.drive_off      = (mode_q == MODE_STOPPED);
        r.duty           = duty_q;
        r.motor_mode     = mode_q;
        r.commutated     = fired;
        r.detector_reset = cl_entry;
        r.step_index     = step_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // event driver: predicts on each accepted transaction, then refills
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            expected_outputs.push_back(apply_event(item));
            events_taken <= events_taken + 1;
        end
        // slot is free when idle or when the held event was just taken
        if (rst_n && (!item_valid || item_ready))
        begin
            if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= event_queue.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off, fired once so the block backs up its input
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result monitor: compares each transaction with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_outputs.size() == 0)
            begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("result %0d arrived with nothing predicted", results_seen);
            end
            else
            begin
                out_item_t want;
                want = expected_outputs.pop_front();
                if (result.high_phase !== want.high_phase || result.low_phase !== want.low_phase
                    || result.float_phase !== want.float_phase
                    || result.drive_off !== want.drive_off || result.duty !== want.duty
                    || result.motor_mode !== want.motor_mode
                    || result.commutated !== want.commutated
                    || result.detector_reset !== want.detector_reset
                    || result.step_index !== want.step_index)
                begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                    begin
                        $display("result %0d mismatch at %0t", results_seen, $realtime);
                        $display("  expected hi %0d lo %0d fl %0d off %0b duty %0d mode %0d comm %0b dres %0b step %0d",
                                 want.high_phase, want.low_phase, want.float_phase, want.drive_off,
                                 want.duty, want.motor_mode, want.commutated, want.detector_reset,
                                 want.step_index);
                        $display("  actual   hi %0d lo %0d fl %0d off %0b duty %0d mode %0d comm %0b dres %0b step %0d",
                                 result.high_phase, result.low_phase, result.float_phase,
                                 result.drive_off, result.duty, result.motor_mode, result.commutated,
                                 result.detector_reset, result.step_index);
                    end
                end
            end
        end
        result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_event(input logic [OP_W-1:0] op, input logic [31:0] t,
                               input logic [THR_W-1:0] thr);
        in_item_t ev;
        ev.op         = op;
        ev.time_ticks = t;
        ev.throttle   = thr;
        event_queue.push_back(ev);
        events_queued = events_queued + 1;
    endtask

    // block until every queued event is taken and every result is back
    task automatic wait_quiet();
        while (events_taken != events_queued || expected_outputs.size() != 0)
            @(posedge clk);
    endtask

    // one register write transaction, shadow updated at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INITIAL_PERIOD: cfg_init_period  = data;
            REG_FINAL_PERIOD:   cfg_final_period = data;
            REG_RAMP_STEPS:     cfg_ramp_steps   = data;
            REG_RAMP_DECREMENT: cfg_ramp_dec     = data;
            REG_BLANKING_TICKS: cfg_blanking     = data;
            REG_THROTTLE_MIN:   cfg_thr_min      = data[THR_W-1:0];
            REG_MAX_DUTY:       cfg_max_duty     = data;
            default:            ;
        endcase
        reg_writes = reg_writes + 1;
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] init_p, input logic [CFG_W-1:0] final_p,
                                 input logic [CFG_W-1:0] steps, input logic [CFG_W-1:0] dec,
                                 input logic [CFG_W-1:0] blank, input logic [CFG_W-1:0] thr_min,
                                 input logic [CFG_W-1:0] max_d);
        write_reg(REG_INITIAL_PERIOD, init_p);
        write_reg(REG_FINAL_PERIOD, final_p);
        write_reg(REG_RAMP_STEPS, steps);
        write_reg(REG_RAMP_DECREMENT, dec);
        write_reg(REG_BLANKING_TICKS, blank);
        write_reg(REG_THROTTLE_MIN, thr_min);
        write_reg(REG_MAX_DUTY, max_d);
        settings_used = settings_used + 1;
    endtask

    // mid-range settings with a short ramp so closed loop is reached often
    task automatic load_random_settings();
        int unsigned ip;
        ip = $urandom_range(200, 3000);
        load_settings(CFG_W'(ip), CFG_W'($urandom_range(50, ip)), CFG_W'($urandom_range(2, 10)),
                      CFG_W'($urandom_range(0, 400)), CFG_W'($urandom_range(0, 300)),
                      CFG_W'($urandom_range(0, 2046)), CFG_W'($urandom_range(1, 65535)));
    endtask

    // random event of any kind, any time, often a stop
    task automatic noise_event();
        logic [OP_W-1:0]  op;
        logic [THR_W-1:0] thr;
        op  = ($urandom_range(19) == 0) ? OP_NONE : OP_W'($urandom_range(0, 2));
        thr = ($urandom_range(3) == 0) ? '0 : THR_W'($urandom_range(0, 2047));
        queue_event(op, $urandom(), thr);
    endtask

    // well-formed spin-up: start, open-loop ramp on schedule, closed-loop
    // crossings with their commutations, mostly ending in a stop
    task automatic spin_sequence();
        logic [31:0] t;
        logic [31:0] sched;
        logic [31:0] lc;
        logic [31:0] c;
        logic [31:0] c_prev;
        logic        have_prev;
        int unsigned per;
        int unsigned steps;
        int unsigned n;
        int unsigned i;
        int unsigned iv;
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6)
            t = $urandom_range(1, 32'h7000_0000);
        else if (r < 8)
            t = $urandom_range(0, 1000);
        else
            t = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        queue_event(OP_THROTTLE, $urandom(), THR_W'($urandom_range(1, 2047)));
        per = {16'd0, cfg_init_period};
        // start schedules at time zero: upper-half times wait for the wrap
        if (t[31])
        begin
            queue_event(OP_TICK, t, THR_W'($urandom_range(0, 2047)));
            sched = $urandom_range(0, 64);
        end
        else
            sched = t;
        steps = ((cfg_ramp_steps > 16'd12) ? 32'd12 : {16'd0, cfg_ramp_steps})
                + $urandom_range(0, 2);
        for (i = 0; i < steps; i++)
        begin
            if ($urandom_range(3) == 0)
                queue_event(OP_TICK, sched - $urandom_range(1, per),
                            THR_W'($urandom_range(0, 2047)));
            if ($urandom_range(9) == 0)
                queue_event(OP_CROSS, sched - 1, THR_W'($urandom_range(0, 2047)));
            if ($urandom_range(9) == 0)
                queue_event(OP_THROTTLE, $urandom(), THR_W'($urandom_range(1, 2047)));
            t = sched + $urandom_range(0, 3);
            queue_event(OP_TICK, t, THR_W'($urandom_range(0, 2047)));
            per = ({16'd0, cfg_ramp_dec} > per
                   || per - {16'd0, cfg_ramp_dec} < {16'd0, cfg_final_period})
                  ? {16'd0, cfg_final_period} : per - {16'd0, cfg_ramp_dec};
            sched = t + per;
        end
        if (steps >= {16'd0, cfg_ramp_steps})
        begin
            // leftover open-loop schedule fires once in closed loop
            if ($urandom_range(1) == 0)
                queue_event(OP_TICK, sched - 1, THR_W'($urandom_range(0, 2047)));
            queue_event(OP_TICK, sched + $urandom_range(0, 2), THR_W'($urandom_range(0, 2047)));
            lc        = sched;
            have_prev = 1'b0;
            c_prev    = '0;
            iv        = $urandom_range(4, 4000);
            n         = $urandom_range(2, 8);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(6) == 0)
                    c = lc + $urandom_range(0, {16'd0, cfg_blanking});
                else
                    c = lc + {16'd0, cfg_blanking} + $urandom_range(0, iv);
                queue_event(OP_CROSS, c, THR_W'($urandom_range(0, 2047)));
                if ((c - lc) >= {16'd0, cfg_blanking})
                begin
                    if (have_prev)
                    begin
                        sched = c + ((c - c_prev) >> 1);
                        if ($urandom_range(2) == 0)
                            queue_event(OP_TICK, sched - 1, THR_W'($urandom_range(0, 2047)));
                        t = sched + $urandom_range(0, 2);
                        queue_event(OP_TICK, t, THR_W'($urandom_range(0, 2047)));
                        lc = sched;
                        // a second tick finds nothing armed
                        if ($urandom_range(2) == 0)
                            queue_event(OP_TICK, t + 1, THR_W'($urandom_range(0, 2047)));
                    end
                    c_prev    = c;
                    have_prev = 1'b1;
                end
            end
        end
        if ($urandom_range(9) < 6)
            queue_event(OP_THROTTLE, $urandom(), '0);
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned first;
        first = events_queued;
        while (events_queued - first < budget)
        begin
            if ($urandom_range(4) == 0)
                noise_event();
            else
                spin_sequence();
        end
        wait_quiet();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset state: events in the wrong mode and the no-event code
        queue_event(OP_TICK, 32'hFFFF_FFFF, 11'd0);
        queue_event(OP_CROSS, 32'd6, 11'd2047);
        queue_event(OP_NONE, 32'd7, 11'd2047);
        wait_quiet();

        // directed walk: oversize decrement forces the floor, ramp of three
        load_settings(16'd1000, 16'd900, 16'd3, 16'd65535, 16'd100, 16'd48, 16'd1000);
        queue_event(OP_THROTTLE, 32'd0, 11'd0);      // stop while stopped
        queue_event(OP_THROTTLE, 32'd1, 11'd2047);   // start at full throttle
        queue_event(OP_THROTTLE, 32'd2, 11'd1);      // below minimum while running
        queue_event(OP_THROTTLE, 32'd3, 11'd48);     // exactly at minimum
        queue_event(OP_THROTTLE, 32'd4, 11'd1000);
        queue_event(OP_CROSS, 32'd10, 11'd0);        // crossing in open loop is ignored
        queue_event(OP_TICK, 32'd100, 11'd0);        // first step, period drops to floor
        queue_event(OP_TICK, 32'd500, 11'd0);        // not due
        queue_event(OP_TICK, 32'd1000, 11'd0);
        queue_event(OP_TICK, 32'd1900, 11'd0);       // enters closed loop
        queue_event(OP_TICK, 32'd2000, 11'd0);       // armed but not due
        queue_event(OP_TICK, 32'd2800, 11'd0);       // leftover schedule fires
        queue_event(OP_TICK, 32'd3000, 11'd0);       // nothing armed
        queue_event(OP_CROSS, 32'd2850, 11'd0);      // inside blanking
        queue_event(OP_CROSS, 32'd2900, 11'd0);      // first crossing, stored only
        queue_event(OP_CROSS, 32'd3100, 11'd0);      // schedules at half interval
        queue_event(OP_TICK, 32'd3200, 11'd0);
        queue_event(OP_CROSS, 32'd0, 11'd0);         // crossing at time zero
        queue_event(OP_CROSS, 32'd400, 11'd0);       // zero stored: counts as none
        queue_event(OP_THROTTLE, 32'hFFFF_FFFF, 11'd0);
        queue_event(OP_TICK, 32'h8000_0000, 11'd2047);
        wait_quiet();

        // sender mostly busy, receiver mostly stalled
        load_settings(16'd65535, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd65535);
        run_phase(PHASE_EVENTS);

        // roles swapped
        send_idle_pct = 86;
        recv_idle_pct = 9;
        load_settings(16'd1, 16'd65535, 16'd5, 16'd1, 16'd65535, 16'd2046, 16'd65535);
        run_phase(PHASE_EVENTS);
        load_random_settings();
        run_phase(PHASE_EVENTS);

        // no idling on either side; ramp never completes here
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(CFG_W'($urandom_range(100, 2000)), CFG_W'($urandom_range(1, 100)),
                      16'd65535, CFG_W'($urandom_range(0, 50)), CFG_W'($urandom_range(0, 300)),
                      CFG_W'($urandom_range(0, 2046)), 16'd0);
        run_phase(PHASE_EVENTS);

        // long receiver hold-off while the sender keeps offering
        hold_armed = 1'b1;
        load_random_settings();
        run_phase(PHASE_EVENTS);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d events through %0d register settings (%0d register writes)",
                 events_taken, settings_used, reg_writes);
        $display("checked %0d results, %0d mismatches", results_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_outputs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
